### rtl/ppts_pkg.sv
// Shared constants and types for the perspective point-to-screen pipeline.
package ppts_pkg;

    localparam int POS_FRAC_BITS  = 16;
    localparam int COEF_FRAC_BITS = 24;
    localparam int OUT_FRAC_BITS  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_W      = 95;
    localparam int DEN_W      = 63;
    localparam int QUO_BITS   = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LO    = 3'd0,
        REG_X_HI    = 3'd1,
        REG_Y_LO    = 3'd2,
        REG_Y_HI    = 3'd3,
        REG_W_LO    = 3'd4,
        REG_W_HI    = 3'd5,
        REG_VIEWPORT = 3'd6
    } cfg_reg_t;

endpackage

### rtl/ppts_div.sv
// Pipelined saturating divider, one quotient bit per stage.
module ppts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ppts_pkg::NUM_W-1:0]  num,
    input  logic [ppts_pkg::DEN_W-1:0]  den,
    input  logic                        neg,
    input  logic                        keep,
    output logic                        out_valid,
    output logic [31:0]                 quo
);
    import ppts_pkg::*;

    localparam int LOW_W = QUO_BITS;

    logic [DEN_W-1:0]    rem_reg  [0:QUO_BITS];
    logic [LOW_W-1:0]    low_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg    [0:QUO_BITS];
    logic [DEN_W-1:0]    den_reg  [0:QUO_BITS];
    logic                neg_reg  [0:QUO_BITS];
    logic                keep_reg [0:QUO_BITS];
    logic                ovf_reg  [0:QUO_BITS];
    logic                vld_reg  [0:QUO_BITS];

    logic [DEN_W-1:0] head;
    assign head = {1'b0, num[NUM_W-1:LOW_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= head;
        low_reg[0]  <= num[LOW_W-1:0];
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        neg_reg[0]  <= neg;
        keep_reg[0] <= keep;
        ovf_reg[0]  <= (head >= den);
    end

    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W:0]   diff;
        assign trial = {rem_reg[k-1], low_reg[k-1][LOW_W-1]};
        assign take  = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg[k]  <= {low_reg[k-1][LOW_W-2:0], 1'b0};
            q_reg[k]    <= {q_reg[k-1][QUO_BITS-2:0], take};
            den_reg[k]  <= den_reg[k-1];
            neg_reg[k]  <= neg_reg[k-1];
            keep_reg[k] <= keep_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
        end
    end

    logic [QUO_BITS-1:0] qf;
    logic [31:0]         res_next;
    logic [31:0]         res_reg;
    logic                vout_reg;

    assign qf = q_reg[QUO_BITS];

    always_comb
    begin
        if (!keep_reg[QUO_BITS])
        begin
            res_next = '0;
        end
        else if (neg_reg[QUO_BITS])
        begin
            if (ovf_reg[QUO_BITS] || qf > {1'b0, 32'h8000_0000})
                res_next = 32'h8000_0000;
            else
                res_next = 32'd0 - qf[31:0];
        end
        else
        begin
            if (ovf_reg[QUO_BITS] || qf > {1'b0, 32'h7FFF_FFFF})
                res_next = 32'h7FFF_FFFF;
            else
                res_next = qf[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= vld_reg[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vout_reg;
    assign quo       = res_reg;

endmodule

### rtl/perspective_point_to_screen.sv
// Top level: projects one point through the view matrix onto the screen.
// A result strobes on done once the item has passed stages 1 to 5 and both dividers.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Depth is set by the 33-stage bit-per-stage dividers for x and y.
// Reset: rst_n clears all valid bits and every configuration register to 0.
module perspective_point_to_screen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ppts_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ppts_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [31:0]               pos_x,
    input  logic signed [31:0]               pos_y,
    input  logic signed [31:0]               pos_z,
    output logic                             done,
    output logic signed [31:0]               screen_x,
    output logic signed [31:0]               screen_y,
    output logic                             visible
);
    import ppts_pkg::*;

    localparam int TSH = POS_FRAC_BITS - 2;
    localparam int VSH = OUT_FRAC_BITS - 1;

    logic [63:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg, wlo_reg, whi_reg;
    logic [31:0] vp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xlo_reg <= '0;
            xhi_reg <= '0;
            ylo_reg <= '0;
            yhi_reg <= '0;
            wlo_reg <= '0;
            whi_reg <= '0;
            vp_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_X_LO:     xlo_reg <= wr_data;
                REG_X_HI:     xhi_reg <= wr_data;
                REG_Y_LO:     ylo_reg <= wr_data;
                REG_Y_HI:     yhi_reg <= wr_data;
                REG_W_LO:     wlo_reg <= wr_data;
                REG_W_HI:     whi_reg <= wr_data;
                REG_VIEWPORT: vp_reg  <= wr_data[31:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: products
    logic signed [63:0] px_x, px_y, px_z, py_x, py_y, py_z, pw_x, pw_y, pw_z;
    assign px_x = $signed(xlo_reg[31:0])  * pos_x;
    assign px_y = $signed(xlo_reg[63:32]) * pos_y;
    assign px_z = $signed(xhi_reg[31:0])  * pos_z;
    assign py_x = $signed(ylo_reg[31:0])  * pos_x;
    assign py_y = $signed(ylo_reg[63:32]) * pos_y;
    assign py_z = $signed(yhi_reg[31:0])  * pos_z;
    assign pw_x = $signed(wlo_reg[31:0])  * pos_x;
    assign pw_y = $signed(wlo_reg[63:32]) * pos_y;
    assign pw_z = $signed(whi_reg[31:0])  * pos_z;

    logic signed [63:0] s1_p_reg [0:8];
    logic               v1_reg;

    always_ff @(posedge clk)
    begin
        s1_p_reg[0] <= px_x;
        s1_p_reg[1] <= px_y;
        s1_p_reg[2] <= px_z;
        s1_p_reg[3] <= py_x;
        s1_p_reg[4] <= py_y;
        s1_p_reg[5] <= py_z;
        s1_p_reg[6] <= pw_x;
        s1_p_reg[7] <= pw_y;
        s1_p_reg[8] <= pw_z;
    end

    // stage 2: row sums
    logic signed [63:0] tx, ty, tw, sx, sy, sw;
    assign tx = {{(32-TSH){xhi_reg[63]}}, xhi_reg[63:32], {TSH{1'b0}}};
    assign ty = {{(32-TSH){yhi_reg[63]}}, yhi_reg[63:32], {TSH{1'b0}}};
    assign tw = {{(32-TSH){whi_reg[63]}}, whi_reg[63:32], {TSH{1'b0}}};
    assign sx = (s1_p_reg[0] >>> 2) + (s1_p_reg[1] >>> 2) + (s1_p_reg[2] >>> 2) + tx;
    assign sy = (s1_p_reg[3] >>> 2) + (s1_p_reg[4] >>> 2) + (s1_p_reg[5] >>> 2) + ty;
    assign sw = (s1_p_reg[6] >>> 2) + (s1_p_reg[7] >>> 2) + (s1_p_reg[8] >>> 2) + tw;

    logic signed [63:0] x2_reg, y2_reg, w2_reg;
    logic               v2_reg;

    always_ff @(posedge clk)
    begin
        x2_reg <= sx;
        y2_reg <= sy;
        w2_reg <= sw;
    end

    // stage 3: numerators, sign and magnitude
    logic signed [63:0] nx, ny;
    logic               vis3;
    assign nx   = x2_reg + w2_reg;
    assign ny   = w2_reg - y2_reg;
    assign vis3 = !w2_reg[63] && (w2_reg != 64'sd0);

    logic [63:0]      mx3_reg, my3_reg;
    logic             nx3_reg, ny3_reg, vis3_reg, v3_reg;
    logic [DEN_W-1:0] d3_reg;

    always_ff @(posedge clk)
    begin
        mx3_reg  <= nx[63] ? 64'd0 - nx : nx;
        my3_reg  <= ny[63] ? 64'd0 - ny : ny;
        nx3_reg  <= nx[63];
        ny3_reg  <= ny[63];
        vis3_reg <= vis3;
        d3_reg   <= w2_reg[DEN_W-1:0];
    end

    // stage 4: partial products with the viewport scale
    logic [30:0] mw, mh;
    assign mw = {vp_reg[15:0], {VSH{1'b0}}};
    assign mh = {vp_reg[31:16], {VSH{1'b0}}};

    logic [62:0]      xl4_reg, xh4_reg, yl4_reg, yh4_reg;
    logic             nx4_reg, ny4_reg, vis4_reg, v4_reg;
    logic [DEN_W-1:0] d4_reg;

    always_ff @(posedge clk)
    begin
        xl4_reg  <= 63'(mx3_reg[31:0])  * 63'(mw);
        xh4_reg  <= 63'(mx3_reg[63:32]) * 63'(mw);
        yl4_reg  <= 63'(my3_reg[31:0])  * 63'(mh);
        yh4_reg  <= 63'(my3_reg[63:32]) * 63'(mh);
        nx4_reg  <= nx3_reg;
        ny4_reg  <= ny3_reg;
        vis4_reg <= vis3_reg;
        d4_reg   <= d3_reg;
    end

    // stage 5: full numerators
    logic [NUM_W-1:0] nmx5_reg, nmy5_reg;
    logic             nx5_reg, ny5_reg, vis5_reg, v5_reg;
    logic [DEN_W-1:0] d5_reg;

    always_ff @(posedge clk)
    begin
        nmx5_reg <= {xh4_reg, 32'd0} + {32'd0, xl4_reg};
        nmy5_reg <= {yh4_reg, 32'd0} + {32'd0, yl4_reg};
        nx5_reg  <= nx4_reg;
        ny5_reg  <= ny4_reg;
        vis5_reg <= vis4_reg;
        d5_reg   <= d4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // visibility rides alongside the dividers
    logic vis_pipe_reg [0:QUO_BITS+1];

    always_ff @(posedge clk)
    begin
        vis_pipe_reg[0] <= vis5_reg;
        for (int i = 1; i <= QUO_BITS + 1; i++)
        begin
            vis_pipe_reg[i] <= vis_pipe_reg[i-1];
        end
    end

    logic        vx, vy;
    logic [31:0] qx, qy;

    ppts_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (nmx5_reg),
        .den       (d5_reg),
        .neg       (nx5_reg),
        .keep      (vis5_reg),
        .out_valid (vx),
        .quo       (qx)
    );

    ppts_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (nmy5_reg),
        .den       (d5_reg),
        .neg       (ny5_reg),
        .keep      (vis5_reg),
        .out_valid (vy),
        .quo       (qy)
    );

    assign done     = vx && vy;
    assign screen_x = $signed(qx);
    assign screen_y = $signed(qy);
    assign visible  = vis_pipe_reg[QUO_BITS+1];

endmodule

### tb/perspective_point_to_screen_test.sv
// Testbench for perspective_point_to_screen: directed table plus random points.
`timescale 1ns / 100ps

module perspective_point_to_screen_test;
    import ppts_pkg::*;

    localparam int LATENCY = 40;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               vis;
    } screen_pt_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        bit                 typed;
        screen_pt_t         want;
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic        start;
    logic        busy;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic        done;
    logic signed [31:0] screen_x, screen_y;
    logic        visible;

    logic [63:0] view_regs [0:5];
    logic [31:0] viewport;
    screen_pt_t  pending_pts [$];
    int          mismatches;
    bit          quiet;

    perspective_point_to_screen uut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .start(start), .busy(busy), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .screen_x(screen_x), .screen_y(screen_y), .visible(visible)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [63:0] row_dot(logic [63:0] lo, logic [63:0] hi,
                                                   logic signed [31:0] px,
                                                   logic signed [31:0] py,
                                                   logic signed [31:0] pz);
        logic signed [63:0] acc;
        acc = ($signed(lo[31:0]) * 64'(px)) >>> 2;
        acc = acc + (($signed(lo[63:32]) * 64'(py)) >>> 2);
        acc = acc + (($signed(hi[31:0]) * 64'(pz)) >>> 2);
        acc = acc + (64'($signed(hi[63:32])) <<< (POS_FRAC_BITS - 2));
        return acc;
    endfunction

    function automatic logic [31:0] pixel_quotient(logic signed [64:0] num, logic [15:0] scale,
                                                   logic signed [63:0] den);
        logic [64:0]  mag;
        logic [127:0] prod, quo;
        mag  = num[64] ? -num : num;
        prod = 128'(mag) * 128'(scale) << (OUT_FRAC_BITS - 1);
        quo  = prod / 128'(den);
        if (num[64])
            return (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
        return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    endfunction

    function automatic screen_pt_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                                 logic signed [31:0] pz);
        logic signed [63:0] cx, cy, cw;
        screen_pt_t r;
        cx = row_dot(view_regs[REG_X_LO], view_regs[REG_X_HI], px, py, pz);
        cy = row_dot(view_regs[REG_Y_LO], view_regs[REG_Y_HI], px, py, pz);
        cw = row_dot(view_regs[REG_W_LO], view_regs[REG_W_HI], px, py, pz);
        r = '0;
        if (cw > 0)
        begin
            r.sx  = pixel_quotient(65'(cx) + 65'(cw), viewport[15:0], cw);
            r.sy  = pixel_quotient(65'(cw) - 65'(cy), viewport[31:16], cw);
            r.vis = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        screen_pt_t w;
        if (rst_n && done)
        begin
            if (pending_pts.size() == 0)
                report_mismatch("unexpected item", screen_x, 0);
            else
            begin
                w = pending_pts.pop_front();
                if (screen_x !== w.sx) report_mismatch("screen_x", screen_x, w.sx);
                if (screen_y !== w.sy) report_mismatch("screen_y", screen_y, w.sy);
                if (visible !== w.vis) report_mismatch("visible", visible, w.vis);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx <= REG_VIEWPORT)
            if (idx == REG_VIEWPORT) viewport = val[31:0];
            else view_regs[idx] = val;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_pts.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, bit typed, screen_pt_t want);
        screen_pt_t pred;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pred = project_point(px, py, pz);
        if (typed && pred !== want)
            report_mismatch("table row", pred[64:33], want[64:33]);
        pending_pts.push_back(pred);
        @(negedge clk);
    endtask

    function automatic logic [31:0] q824(int milli);
        return 32'(longint'(milli) * 64'd16777216 / 1000);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h0;
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    task automatic load_camera(int kind);
        logic [31:0] wide, tall;
        case (kind)
            0: begin wide = 32'hFFFF; tall = 32'hFFFF; end
            1: begin wide = 32'h0; tall = 32'h0; end
            default: begin wide = $urandom_range(1, 4096); tall = $urandom_range(1, 4096); end
        endcase
        write_reg(REG_X_LO, {rand_weight(), $urandom_range(0,3) == 0 ? rand_weight() : q824(1000)});
        write_reg(REG_X_HI, {rand_weight(), rand_weight()});
        write_reg(REG_Y_LO, {$urandom_range(0,3) == 0 ? rand_weight() : q824(1000), rand_weight()});
        write_reg(REG_Y_HI, {rand_weight(), rand_weight()});
        write_reg(REG_W_LO, {rand_weight(), rand_weight()});
        write_reg(REG_W_HI, {$urandom_range(0,3) == 0 ? rand_weight() : q824(4000),
                             $urandom_range(0,3) == 0 ? rand_weight() : q824(-1000)});
        write_reg(REG_VIEWPORT, {$urandom(), tall[15:0], wide[15:0]});
    endtask

    initial
    begin
        point_row_t table_rows [$];
        point_row_t row;
        screen_pt_t zero_pt;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        start = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        quiet = 1'b0;
        mismatches = 0;
        viewport = '0;
        for (int i = 0; i < 6; i++) view_regs[i] = '0;
        zero_pt = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset every weight is zero, so w is zero and nothing is visible
        row = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 1'b1, zero_pt};
        table_rows.push_back(row);
        foreach (table_rows[i])
            send_point(table_rows[i].px, table_rows[i].py, table_rows[i].pz, 1'b1, zero_pt);
        drain();

        // identity-like camera: x=px, y=py, w=1 with a 640x480 viewport
        write_reg(REG_X_LO, {32'h0, q824(1000)});
        write_reg(REG_X_HI, 64'h0);
        write_reg(REG_Y_LO, {q824(1000), 32'h0});
        write_reg(REG_Y_HI, 64'h0);
        write_reg(REG_W_LO, 64'h0);
        write_reg(REG_W_HI, {q824(1000), 32'h0});
        write_reg(REG_VIEWPORT, {16'd480, 16'd640});
        write_reg(3'd7, 64'hDEAD_BEEF_DEAD_BEEF);
        table_rows.delete();
        table_rows.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'sd320 <<< 16, 32'sd240 <<< 16, 1'b1}});
        table_rows.push_back('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0, 1'b1,
                               '{32'sd640 <<< 16, 32'sd480 <<< 16, 1'b1}});
        table_rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 1'b1,
                               '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1}});
        table_rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1,
                               '{32'sh8000_0000, 32'sh8000_0000, 1'b1}});
        table_rows.push_back('{32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000, 1'b0, zero_pt});
        table_rows.push_back('{32'sh1234_5678, 32'shEDCB_A987, 32'sh5555_5555, 1'b0, zero_pt});
        foreach (table_rows[i])
            send_point(table_rows[i].px, table_rows[i].py, table_rows[i].pz,
                       table_rows[i].typed, table_rows[i].want);
        drain();

        // w follows z so points behind the eye drop out
        write_reg(REG_W_HI, {32'h0, q824(1000)});
        table_rows.delete();
        table_rows.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b1, zero_pt});
        table_rows.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'shFFFF_0000, 1'b1, zero_pt});
        table_rows.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0, zero_pt});
        table_rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001, 1'b0, zero_pt});
        table_rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0001, 1'b0, zero_pt});
        foreach (table_rows[i])
            send_point(table_rows[i].px, table_rows[i].py, table_rows[i].pz,
                       table_rows[i].typed, table_rows[i].want);
        drain();

        // zero viewport flattens every visible point to the origin
        write_reg(REG_VIEWPORT, 64'h0);
        send_point(32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b1, '{32'sh0, 32'sh0, 1'b1});
        drain();

        // extreme weights
        write_reg(REG_X_LO, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_X_HI, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_Y_LO, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_Y_HI, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_W_LO, 64'h0000_0001_FFFF_FFFF);
        write_reg(REG_W_HI, 64'h7FFF_FFFF_0000_0001);
        write_reg(REG_VIEWPORT, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, zero_pt);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            load_camera(phase % 3);
            quiet = (phase == 8);
            for (int i = 0; i < 50; i++)
                send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, zero_pt);
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
